// File: hdl/cmbm_pkg.sv
package cmbm_pkg;

    localparam int CH_W       = 8;
    localparam int SUBJ_W     = 3;
    localparam int NUM_COLORS = 8;
    localparam int DIST_W     = 18;
    localparam int COUNT_W    = 25;
    localparam int POS_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int FW_W       = 13;
    localparam int SC_W       = 4;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // Largest accepted squared distance: 0.2 of the full-scale distance, squared, in 8-bit units
    localparam logic [DIST_W-1:0]  THRESH    = 18'd7803;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [FW_W-1:0]    FW_RESET  = 13'd320;
    localparam logic [SC_W-1:0]    SC_RESET  = 4'd8;

    typedef enum logic {
        REG_FRAME_WIDTH   = 1'b0,
        REG_SUBJECT_COUNT = 1'b1
    } reg_index_t;

    localparam logic [CH_W-1:0] COLOR_RED [NUM_COLORS] =
        '{8'd55, 8'd255, 8'd168, 8'd255, 8'd255, 8'd157, 8'd255, 8'd54};
    localparam logic [CH_W-1:0] COLOR_GREEN [NUM_COLORS] =
        '{8'd213, 8'd159, 8'd255, 8'd79, 8'd225, 8'd112, 8'd93, 8'd224};
    localparam logic [CH_W-1:0] COLOR_BLUE [NUM_COLORS] =
        '{8'd255, 8'd67, 8'd62, 8'd179, 8'd74, 8'd255, 8'd93, 8'd160};

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
    } pixel_t;

    typedef struct packed {
        logic [SUBJ_W-1:0]  subject;
        logic               visible;
        logic [COUNT_W-1:0] pixel_count;
        logic [POS_W-1:0]   rect_x;
        logic [POS_W-1:0]   rect_y;
        logic [SIZE_W-1:0]  rect_width;
        logic [SIZE_W-1:0]  rect_height;
        logic               last_subject;
    } result_t;

    function automatic logic [DIST_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
        logic [CH_W-1:0]   d;
        logic [2*CH_W-1:0] sq;
        d  = (a > b) ? a - b : b - a;
        sq = {{CH_W{1'b0}}, d} * {{CH_W{1'b0}}, d};
        return {{(DIST_W-2*CH_W){1'b0}}, sq};
    endfunction

endpackage

// File: hdl/cmbm_queue.sv
module cmbm_queue import cmbm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hdl/cmbm_front.sv
module cmbm_front import cmbm_pkg::*;
#(
    parameter int MAX_SUBJECTS = 8,
    parameter int MAX_DIM      = 4096
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  pixel_t                     pixel,
    input  logic [FW_W-1:0]            frame_width,
    input  logic [SC_W-1:0]            active,
    output logic                       entry_valid,
    output logic                       entry_hit,
    output logic [SUBJ_W-1:0]          entry_id,
    output logic [$clog2(MAX_DIM)-1:0] entry_column,
    output logic [$clog2(MAX_DIM)-1:0] entry_row,
    output logic                       entry_last
);

    localparam int CW   = $clog2(MAX_DIM);
    localparam int CMPW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

    logic [CW-1:0]     col_reg, col_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [CMPW-1:0]   fw_ext;
    logic [CMPW-1:0]   width_eff;
    logic [CMPW-1:0]   col_inc;

    logic              s1_valid_reg;
    logic [DIST_W-1:0] s1_dist_reg [MAX_SUBJECTS];
    logic [MAX_SUBJECTS-1:0] s1_en_reg;
    logic [CW-1:0]     s1_col_reg;
    logic [CW-1:0]     s1_row_reg;
    logic              s1_last_reg;

    logic              found;
    logic [DIST_W-1:0] best_d;
    logic [SUBJ_W-1:0] best_i;

    // Raster position tracking
    always_comb
    begin
        fw_ext = CMPW'(frame_width);
        if (fw_ext == '0)
        begin
            width_eff = CMPW'(1);
        end
        else if (fw_ext > CMPW'(MAX_DIM))
        begin
            width_eff = CMPW'(MAX_DIM);
        end
        else
        begin
            width_eff = fw_ext;
        end
        col_inc  = CMPW'(col_reg) + 1'b1;
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (pixel.frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= width_eff)
            begin
                col_next = '0;
                if (row_reg < CW'(MAX_DIM - 1))
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
        end
    end

    // Distance stage: one squared distance per subject lane
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_SUBJECTS; i++)
            begin
                s1_dist_reg[i] <= sq_diff(pixel.red,   COLOR_RED[i])
                                + sq_diff(pixel.green, COLOR_GREEN[i])
                                + sq_diff(pixel.blue,  COLOR_BLUE[i]);
                s1_en_reg[i]   <= (SC_W'(i) < active);
            end
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_last_reg <= pixel.frame_end;
        end
    end

    // Nearest subject, lower index wins ties
    always_comb
    begin
        found  = 1'b0;
        best_d = '0;
        best_i = '0;
        for (int i = 0; i < MAX_SUBJECTS; i++)
        begin
            if (s1_en_reg[i] && (!found || s1_dist_reg[i] < best_d))
            begin
                found  = 1'b1;
                best_d = s1_dist_reg[i];
                best_i = SUBJ_W'(i);
            end
        end
    end

    assign entry_valid  = s1_valid_reg;
    assign entry_hit    = found && (best_d <= THRESH);
    assign entry_id     = best_i;
    assign entry_column = s1_col_reg;
    assign entry_row    = s1_row_reg;
    assign entry_last   = s1_last_reg;

endmodule

// File: hdl/cmbm_back.sv
module cmbm_back import cmbm_pkg::*;
#(
    parameter int MAX_SUBJECTS = 8,
    parameter int MAX_DIM      = 4096
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       entry_valid,
    input  logic                       entry_hit,
    input  logic [SUBJ_W-1:0]          entry_id,
    input  logic [$clog2(MAX_DIM)-1:0] entry_column,
    input  logic [$clog2(MAX_DIM)-1:0] entry_row,
    input  logic                       entry_last,
    input  logic [SC_W-1:0]            active,
    output logic                       entry_pop,
    input  logic                       rec_ready,
    output logic                       rec_push,
    output result_t                    rec
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int IDX_W = (MAX_SUBJECTS > 1) ? $clog2(MAX_SUBJECTS) : 1;

    logic [COUNT_W-1:0] cnt_reg   [MAX_SUBJECTS];
    logic [CW-1:0]      minx_reg  [MAX_SUBJECTS];
    logic [CW-1:0]      maxx_reg  [MAX_SUBJECTS];
    logic [CW-1:0]      miny_reg  [MAX_SUBJECTS];
    logic [CW-1:0]      maxy_reg  [MAX_SUBJECTS];
    logic [COUNT_W-1:0] cnt_next  [MAX_SUBJECTS];
    logic [CW-1:0]      minx_next [MAX_SUBJECTS];
    logic [CW-1:0]      maxx_next [MAX_SUBJECTS];
    logic [CW-1:0]      miny_next [MAX_SUBJECTS];
    logic [CW-1:0]      maxy_next [MAX_SUBJECTS];

    logic [COUNT_W-1:0] snap_cnt_reg  [MAX_SUBJECTS];
    logic [CW-1:0]      snap_minx_reg [MAX_SUBJECTS];
    logic [CW-1:0]      snap_maxx_reg [MAX_SUBJECTS];
    logic [CW-1:0]      snap_miny_reg [MAX_SUBJECTS];
    logic [CW-1:0]      snap_maxy_reg [MAX_SUBJECTS];
    logic               snap_busy_reg, snap_busy_next;
    logic [SC_W-1:0]    snap_total_reg, snap_total_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;

    logic               take;
    logic               close_frame;
    logic               rec_last;
    logic               rec_vis;
    logic [CW:0]        span_x;
    logic [CW:0]        span_y;

    // Hold a frame end until the previous readout has drained
    assign take        = entry_valid && (!entry_last || !snap_busy_reg);
    assign entry_pop   = take;
    assign close_frame = take && entry_last;

    // Per-subject update lanes
    always_comb
    begin
        for (int i = 0; i < MAX_SUBJECTS; i++)
        begin
            cnt_next[i]  = cnt_reg[i];
            minx_next[i] = minx_reg[i];
            maxx_next[i] = maxx_reg[i];
            miny_next[i] = miny_reg[i];
            maxy_next[i] = maxy_reg[i];
            if (take && entry_hit && entry_id == SUBJ_W'(i))
            begin
                if (cnt_reg[i] == '0)
                begin
                    minx_next[i] = entry_column;
                    maxx_next[i] = entry_column;
                    miny_next[i] = entry_row;
                    maxy_next[i] = entry_row;
                end
                else
                begin
                    if (entry_column < minx_reg[i]) minx_next[i] = entry_column;
                    if (entry_column > maxx_reg[i]) maxx_next[i] = entry_column;
                    if (entry_row < miny_reg[i])    miny_next[i] = entry_row;
                    if (entry_row > maxy_reg[i])    maxy_next[i] = entry_row;
                end
                if (cnt_reg[i] != COUNT_MAX)
                begin
                    cnt_next[i] = cnt_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SUBJECTS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_SUBJECTS; i++)
            begin
                cnt_reg[i] <= close_frame ? '0 : cnt_next[i];
            end
        end
    end

    // Box corners only count once the lane's count is nonzero
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_SUBJECTS; i++)
        begin
            minx_reg[i] <= minx_next[i];
            maxx_reg[i] <= maxx_next[i];
            miny_reg[i] <= miny_next[i];
            maxy_reg[i] <= maxy_next[i];
        end
        if (close_frame)
        begin
            for (int i = 0; i < MAX_SUBJECTS; i++)
            begin
                snap_cnt_reg[i]  <= cnt_next[i];
                snap_minx_reg[i] <= minx_next[i];
                snap_maxx_reg[i] <= maxx_next[i];
                snap_miny_reg[i] <= miny_next[i];
                snap_maxy_reg[i] <= maxy_next[i];
            end
        end
    end

    // Readout sequencer over the frame snapshot
    assign rec_push = snap_busy_reg && rec_ready;
    assign rec_last = (SC_W'(rd_idx_reg) + 1'b1 == snap_total_reg);

    always_comb
    begin
        snap_busy_next  = snap_busy_reg;
        snap_total_next = snap_total_reg;
        rd_idx_next     = rd_idx_reg;
        if (close_frame)
        begin
            snap_busy_next  = (active != '0);
            snap_total_next = active;
            rd_idx_next     = '0;
        end
        else if (rec_push)
        begin
            if (rec_last)
            begin
                snap_busy_next = 1'b0;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_busy_reg  <= 1'b0;
            snap_total_reg <= '0;
            rd_idx_reg     <= '0;
        end
        else
        begin
            snap_busy_reg  <= snap_busy_next;
            snap_total_reg <= snap_total_next;
            rd_idx_reg     <= rd_idx_next;
        end
    end

    always_comb
    begin
        rec_vis = (snap_cnt_reg[rd_idx_reg] != '0);
        span_x  = {1'b0, snap_maxx_reg[rd_idx_reg]} - {1'b0, snap_minx_reg[rd_idx_reg]}
                + 1'b1;
        span_y  = {1'b0, snap_maxy_reg[rd_idx_reg]} - {1'b0, snap_miny_reg[rd_idx_reg]}
                + 1'b1;
        rec.subject      = SUBJ_W'(rd_idx_reg);
        rec.visible      = rec_vis;
        rec.pixel_count  = rec_vis ? snap_cnt_reg[rd_idx_reg] : '0;
        rec.rect_x       = rec_vis ? POS_W'(snap_minx_reg[rd_idx_reg]) : '0;
        rec.rect_y       = rec_vis ? POS_W'(snap_miny_reg[rd_idx_reg]) : '0;
        rec.rect_width   = rec_vis ? SIZE_W'(span_x) : '0;
        rec.rect_height  = rec_vis ? SIZE_W'(span_y) : '0;
        rec.last_subject = rec_last;
    end

endmodule

// File: hdl/color_mask_box_measure.sv
// Color mask box measure: nearest subject color classification of a
// raster-order pixel stream, with a pixel count and bounding box per subject.
//
// Pixel channel: a queue-style input. Drive pixel and push; a transfer
// happens on a clock edge with push high and full low. Mark the last pixel
// of a frame with frame_end. One pixel per clock is taken while the block
// keeps up; full rises only when frame ends keep waiting behind unfinished
// readouts, i.e. when frames are no longer than the reported subject count.
// Record channel: result holds the oldest record while empty is low; pop
// takes it. A frame end yields one record per active subject, one per cycle
// while the record queue has room. The pipeline is a distance stage, a
// nearest-subject compare, a 4-entry queue, the box update lanes with a
// readout snapshot, and a 2-entry record queue.
// A stalled receiver fills the record queue, then holds the readout, then
// the frame end in the middle queue, and finally raises full; nothing drops.
// Configuration: APB writes to the frame width (offset 0) and the subject
// count (offset 4); the user must write only while the block is idle, as
// the block does not enforce it. Reset: frame width 320, subject count 8,
// all counts and positions zero, both queues empty, full low out of reset.
module color_mask_box_measure import cmbm_pkg::*;
#(
    parameter int MAX_SUBJECTS = 8,
    parameter int MAX_DIM      = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pixel_t            pixel,
    input  logic              push,
    output logic              full,
    output result_t           result,
    output logic              empty,
    input  logic              pop,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CW       = $clog2(MAX_DIM);
    localparam int MQ_DEPTH = 4;
    localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
    localparam int MQ_W     = 1 + SUBJ_W + 2 * CW + 1;
    localparam int OQ_DEPTH = 2;
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    logic [FW_W-1:0]     fw_reg, fw_next;
    logic [SC_W-1:0]     sc_reg, sc_next;
    logic [SC_W-1:0]     active;
    logic                cfg_write;

    logic                accept;
    logic                fe_valid;
    logic                fe_hit;
    logic [SUBJ_W-1:0]   fe_id;
    logic [CW-1:0]       fe_column;
    logic [CW-1:0]       fe_row;
    logic                fe_last;

    logic [MQ_W-1:0]     mq_rdata;
    logic                mq_empty;
    logic                mq_full;
    logic [MQ_CNT_W-1:0] mq_count;
    logic [MQ_CNT_W:0]   mq_credit;

    logic                be_pop;
    logic                be_hit;
    logic [SUBJ_W-1:0]   be_id;
    logic [CW-1:0]       be_column;
    logic [CW-1:0]       be_row;
    logic                be_last;

    logic                rec_push;
    result_t             rec;
    logic                oq_full;
    logic [OQ_CNT_W-1:0] oq_count;
    logic [$bits(result_t)-1:0] oq_rdata;

    // Configuration registers, written on the APB access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        fw_next = fw_reg;
        sc_next = sc_reg;
        if (cfg_write)
        begin
            unique case (reg_index_t'(paddr[2]))
                REG_FRAME_WIDTH:   fw_next = pwdata[FW_W-1:0];
                REG_SUBJECT_COUNT: sc_next = pwdata[SC_W-1:0];
                default:           fw_next = fw_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index_t'(paddr[2]))
            REG_FRAME_WIDTH:   prdata = DATA_W'(fw_reg);
            REG_SUBJECT_COUNT: prdata = DATA_W'(sc_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FW_RESET;
            sc_reg <= SC_RESET;
        end
        else
        begin
            fw_reg <= fw_next;
            sc_reg <= sc_next;
        end
    end

    // Clamp the subject count to the lanes that exist
    assign active = (sc_reg > SC_W'(MAX_SUBJECTS)) ? SC_W'(MAX_SUBJECTS) : sc_reg;

    // Reserve queue room for the pixel still in the distance stage
    assign mq_credit = (MQ_CNT_W + 1)'(mq_count) + (MQ_CNT_W + 1)'(fe_valid);
    assign full      = mq_full || (mq_credit >= (MQ_CNT_W + 1)'(MQ_DEPTH));
    assign accept    = push && !full;

    cmbm_front #(
        .MAX_SUBJECTS (MAX_SUBJECTS),
        .MAX_DIM      (MAX_DIM)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .pixel        (pixel),
        .frame_width  (fw_reg),
        .active       (active),
        .entry_valid  (fe_valid),
        .entry_hit    (fe_hit),
        .entry_id     (fe_id),
        .entry_column (fe_column),
        .entry_row    (fe_row),
        .entry_last   (fe_last)
    );

    cmbm_queue #(
        .WIDTH (MQ_W),
        .DEPTH (MQ_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_valid),
        .wdata ({fe_hit, fe_id, fe_column, fe_row, fe_last}),
        .pop   (be_pop),
        .rdata (mq_rdata),
        .empty (mq_empty),
        .full  (mq_full),
        .count (mq_count)
    );

    assign {be_hit, be_id, be_column, be_row, be_last} = mq_rdata;

    cmbm_back #(
        .MAX_SUBJECTS (MAX_SUBJECTS),
        .MAX_DIM      (MAX_DIM)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (!mq_empty),
        .entry_hit    (be_hit),
        .entry_id     (be_id),
        .entry_column (be_column),
        .entry_row    (be_row),
        .entry_last   (be_last),
        .active       (active),
        .entry_pop    (be_pop),
        .rec_ready    (!oq_full),
        .rec_push     (rec_push),
        .rec          (rec)
    );

    // Record queue parts the readout from the receiver
    cmbm_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OQ_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rec_push),
        .wdata (rec),
        .pop   (pop),
        .rdata (oq_rdata),
        .empty (empty),
        .full  (oq_full),
        .count (oq_count)
    );

    assign result = result_t'(oq_rdata);

endmodule

// File: hdl/cmbm_checker.sv
module cmbm_checker import cmbm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    // Hold a waiting record until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("record changed or vanished before transfer");

    // Leave reset with no record waiting
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("record queue not empty after reset");

    // A subject with no match reports an all-zero box
    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.visible |->
            result.pixel_count == '0 && result.rect_x == '0 && result.rect_y == '0
            && result.rect_width == '0 && result.rect_height == '0)
        else $error("invisible subject with nonzero fields");

    // A visible subject has a count and a nonempty box
    a_visible_box: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.visible |->
            result.pixel_count != '0 && result.rect_width != '0
            && result.rect_height != '0)
        else $error("visible subject with empty count or box");

endmodule

bind color_mask_box_measure cmbm_checker u_cmbm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

// File: bench/color_mask_box_measure_checker.sv
`timescale 1ns / 1ps

module color_mask_box_measure_checker import cmbm_pkg::*;
#(
    parameter int MAX_SUBJECTS = 8,
    parameter int MAX_DIM      = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pixel_t            pixel,
    input  logic              push,
    input  logic              full,
    input  result_t           result,
    input  logic              empty,
    input  logic              pop,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    output int                errors,
    output int                records_due
);

    localparam int NO_SUBJECT = NUM_COLORS;
    localparam int ROW_LAST   = MAX_DIM - 1;

    logic [FW_W-1:0]    frame_width;
    logic [SC_W-1:0]    subj_total;
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   min_x [NUM_COLORS];
    logic [POS_W-1:0]   min_y [NUM_COLORS];
    logic [POS_W-1:0]   max_x [NUM_COLORS];
    logic [POS_W-1:0]   max_y [NUM_COLORS];
    logic [COUNT_W-1:0] hits  [NUM_COLORS];
    result_t            due_records [$];

    function automatic int active_subjects(input logic [SC_W-1:0] sc);
        return (int'(sc) > MAX_SUBJECTS) ? MAX_SUBJECTS : int'(sc);
    endfunction

    function automatic int channel_err(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        int diff;
        diff = int'(a) - int'(b);
        return diff * diff;
    endfunction

    // Nearest subject by squared distance; ties keep the lower index.
    function automatic int nearest_subject(input pixel_t p, input int active);
        int best;
        int best_d;
        int d;
        best   = NO_SUBJECT;
        best_d = 0;
        for (int i = 0; i < active; i++)
        begin
            d = channel_err(p.red, COLOR_RED[i]) + channel_err(p.green, COLOR_GREEN[i])
              + channel_err(p.blue, COLOR_BLUE[i]);
            if (best == NO_SUBJECT || d < best_d)
            begin
                best   = i;
                best_d = d;
            end
        end
        if (best != NO_SUBJECT && best_d <= int'(THRESH))
            return best;
        return NO_SUBJECT;
    endfunction

    task automatic clear_measure();
        column = '0;
        row    = '0;
        for (int i = 0; i < NUM_COLORS; i++)
        begin
            min_x[i] = '0;
            min_y[i] = '0;
            max_x[i] = '0;
            max_y[i] = '0;
            hits[i]  = '0;
        end
    endtask

    task automatic measure_pixel(input pixel_t p);
        int      w;
        int      id;
        int      active;
        result_t rec;
        w = int'(frame_width);
        if (w == 0)
            w = 1;
        if (w > MAX_DIM)
            w = MAX_DIM;
        active = active_subjects(subj_total);
        id     = nearest_subject(p, active);
        if (id != NO_SUBJECT)
        begin
            if (hits[id] == '0)
            begin
                min_x[id] = column;
                max_x[id] = column;
                min_y[id] = row;
                max_y[id] = row;
            end
            else
            begin
                if (column < min_x[id]) min_x[id] = column;
                if (column > max_x[id]) max_x[id] = column;
                if (row < min_y[id])    min_y[id] = row;
                if (row > max_y[id])    max_y[id] = row;
            end
            if (hits[id] != COUNT_MAX)
                hits[id] = hits[id] + 1'b1;
        end
        // advance the raster position; the row sticks at its last value
        if (int'(column) + 1 >= w)
        begin
            column = '0;
            if (int'(row) < ROW_LAST)
                row = row + 1'b1;
        end
        else
            column = column + 1'b1;
        if (p.frame_end)
        begin
            for (int k = 0; k < active; k++)
            begin
                rec              = '0;
                rec.subject      = SUBJ_W'(k);
                rec.last_subject = (k + 1 == active);
                if (hits[k] != '0)
                begin
                    rec.visible     = 1'b1;
                    rec.pixel_count = hits[k];
                    rec.rect_x      = min_x[k];
                    rec.rect_y      = min_y[k];
                    rec.rect_width  = SIZE_W'(int'(max_x[k]) - int'(min_x[k]) + 1);
                    rec.rect_height = SIZE_W'(int'(max_y[k]) - int'(min_y[k]) + 1);
                end
                due_records = {due_records, rec};
            end
            clear_measure();
        end
    endtask

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_record(input result_t got);
        result_t want;
        if (due_records.size() == 0)
        begin
            $error("record: none expected, actual subject %0d", got.subject);
            errors++;
        end
        else
        begin
            want = due_records.pop_front();
            compare_field("subject", DATA_W'(want.subject), DATA_W'(got.subject));
            compare_field("visible", DATA_W'(want.visible), DATA_W'(got.visible));
            compare_field("pixel_count", DATA_W'(want.pixel_count),
                          DATA_W'(got.pixel_count));
            compare_field("rect_x", DATA_W'(want.rect_x), DATA_W'(got.rect_x));
            compare_field("rect_y", DATA_W'(want.rect_y), DATA_W'(got.rect_y));
            compare_field("rect_width", DATA_W'(want.rect_width), DATA_W'(got.rect_width));
            compare_field("rect_height", DATA_W'(want.rect_height),
                          DATA_W'(got.rect_height));
            compare_field("last_subject", DATA_W'(want.last_subject),
                          DATA_W'(got.last_subject));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width = FW_RESET;
            subj_total  = SC_RESET;
            clear_measure();
            due_records.delete();
            errors      = 0;
            records_due = 0;
        end
        else
        begin
            if (pop && !empty)
                check_record(result);
            if (push && !full)
                measure_pixel(pixel);
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (reg_index_t'(paddr[ADDR_W-1:2]))
                        REG_FRAME_WIDTH:   frame_width = pwdata[FW_W-1:0];
                        REG_SUBJECT_COUNT: subj_total  = pwdata[SC_W-1:0];
                    endcase
                end
                else
                begin
                    case (reg_index_t'(paddr[ADDR_W-1:2]))
                        REG_FRAME_WIDTH:
                            compare_field("frame_width readback", DATA_W'(frame_width), prdata);
                        REG_SUBJECT_COUNT:
                            compare_field("subject count readback", DATA_W'(subj_total),
                                          prdata);
                    endcase
                end
            end
            records_due = due_records.size();
        end
    end

endmodule

// File: bench/color_mask_box_measure_tb.sv
`timescale 1ns / 1ps

module color_mask_box_measure_tb;
    import cmbm_pkg::*;

    // Drain time after the last record: the pipeline plus both queues,
    // with margin for a frame end that yields no record at all.
    localparam int SETTLE           = 16;
    // Cycles without any transfer before the run is declared hung.
    localparam int QUIET_LIMIT      = 5000;
    // Length of the long receiver hold-off.
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PER_PHASE = 85;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    pixel_t            pixel   = '0;
    logic              push    = 1'b0;
    logic              full;
    result_t           result;
    logic              empty;
    logic              pop     = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int records_due;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;
    bit hold_req     = 1'b0;

    color_mask_box_measure i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pixel),
        .push    (push),
        .full    (full),
        .result  (result),
        .empty   (empty),
        .pop     (pop),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The checker sees every transfer on both channels and every register
    // access, keeps its own copy of the measurement state and compares.
    color_mask_box_measure_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .push        (push),
        .full        (full),
        .result      (result),
        .empty       (empty),
        .pop         (pop),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .errors      (fail_count),
        .records_due (records_due)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: count cycles in which neither channel moves a transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: stall at random by the current percentage. On a hold request,
    // keep pop low for a long stretch so the block backs up into full.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    function automatic pixel_t pixel_of(input int r, input int g, input int b, input bit last);
        pixel_t p;
        p.red       = CH_W'(r);
        p.green     = CH_W'(g);
        p.blue      = CH_W'(b);
        p.frame_end = last;
        return p;
    endfunction

    function automatic pixel_t subj_pixel(input int i, input bit last);
        return pixel_of(COLOR_RED[i], COLOR_GREEN[i], COLOR_BLUE[i], last);
    endfunction

    function automatic int jitter(input int c, input int spread);
        int v;
        v = c + $urandom_range(0, 2 * spread) - spread;
        if (v < 0)   v = 0;
        if (v > 255) v = 255;
        return v;
    endfunction

    // Mostly colors near a subject, some of them outside the threshold,
    // plus exact subject colors, full noise and saturated corners.
    function automatic pixel_t random_pixel();
        int pick;
        int i;
        pick = $urandom_range(0, 99);
        i    = $urandom_range(0, NUM_COLORS - 1);
        if (pick < 55)
            return pixel_of(jitter(COLOR_RED[i], 60), jitter(COLOR_GREEN[i], 60),
                            jitter(COLOR_BLUE[i], 60), 1'b0);
        if (pick < 70)
            return subj_pixel(i, 1'b0);
        if (pick < 85)
            return pixel_of($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), 1'b0);
        return pixel_of(255 * $urandom_range(0, 1), 255 * $urandom_range(0, 1),
                        255 * $urandom_range(0, 1), 1'b0);
    endfunction

    // Offer one pixel, idling first by the current percentage; hold it until
    // the transfer. Enter and leave at a falling edge.
    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        pixel <= p;
        push  <= 1'b1;
        do @(posedge clk); while (full);
        @(negedge clk);
    endtask

    // Stop sending, wait for every expected record, then let the pipeline
    // settle so that a frame end without records is done as well.
    task automatic wait_drained();
        push <= 1'b0;
        while (records_due != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write a register, then read it back; the checker compares the read.
    task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Pick a new setting, mostly narrow frames, now and then the odd widths
    // and subject counts of zero or above the maximum.
    task automatic shuffle_config();
        int pick;
        int fw;
        int sc;
        wait_drained();
        pick = $urandom_range(0, 9);
        if (pick < 7)
            fw = $urandom_range(1, 8);
        else if (pick == 7)
            fw = 0;
        else if (pick == 8)
            fw = $urandom_range(9, 4096);
        else
            fw = $urandom_range(4097, 8191);
        write_reg(REG_FRAME_WIDTH, DATA_W'(fw));
        pick = $urandom_range(0, 9);
        if (pick < 8)
            sc = $urandom_range(1, 8);
        else if (pick == 8)
            sc = 0;
        else
            sc = $urandom_range(9, 15);
        write_reg(REG_SUBJECT_COUNT, DATA_W'(sc));
    endtask

    task automatic send_frame(input int len);
        pixel_t p;
        for (int i = 0; i < len; i++)
        begin
            p           = random_pixel();
            p.frame_end = (i == len - 1);
            send_pixel(p);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        int sent;
        int len;
        wait_drained();
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        shuffle_config();
        sent = 0;
        while (sent < RANDOM_PER_PHASE)
        begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            send_frame(len);
            sent += len;
            if ($urandom_range(0, 3) == 0)
                shuffle_config();
        end
    endtask

    initial
    begin
        // hold reset, release at a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, every subject color, the threshold edge from
        // both sides and an exact tie between two subjects.
        write_reg(REG_FRAME_WIDTH, 4);
        write_reg(REG_SUBJECT_COUNT, 8);
        send_pixel(pixel_of(0, 0, 0, 1'b0));
        send_pixel(pixel_of(255, 255, 255, 1'b0));
        for (int i = 0; i < NUM_COLORS; i++)
            send_pixel(subj_pixel(i, 1'b0));
        send_pixel(pixel_of(142, 228, 252, 1'b0));   // distance exactly at threshold
        send_pixel(pixel_of(142, 228, 251, 1'b0));   // just beyond it
        send_pixel(pixel_of(255, 43, 129, 1'b1));    // equal distance to two subjects

        // Subject count lowered in the middle of a frame: the upper subjects
        // stop matching and reporting but still get cleared.
        send_pixel(subj_pixel(6, 1'b0));
        send_pixel(subj_pixel(1, 1'b0));
        send_pixel(subj_pixel(7, 1'b0));
        wait_drained();
        write_reg(REG_SUBJECT_COUNT, 3);
        send_pixel(subj_pixel(7, 1'b0));
        send_pixel(subj_pixel(0, 1'b1));

        // No subjects at all: nothing matches and the frame end is silent.
        wait_drained();
        write_reg(REG_SUBJECT_COUNT, 0);
        send_pixel(subj_pixel(0, 1'b0));
        send_pixel(subj_pixel(1, 1'b1));
        wait_drained();
        write_reg(REG_SUBJECT_COUNT, 1);
        send_pixel(subj_pixel(0, 1'b0));
        send_pixel(subj_pixel(1, 1'b1));
        wait_drained();
        write_reg(REG_SUBJECT_COUNT, 15);             // above the maximum
        send_pixel(subj_pixel(7, 1'b1));

        // Random frames under each idling pattern.
        run_phase(0, 0);
        run_phase(71, 0);
        run_phase(0, 71);
        run_phase(20, 20);

        // Long receiver hold-off while single-pixel frames keep coming:
        // the record queue fills and the block raises full.
        wait_drained();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_reg(REG_FRAME_WIDTH, 4);
        write_reg(REG_SUBJECT_COUNT, 8);
        hold_req = 1'b1;
        for (int n = 0; n < 24; n++)
            send_frame(1);

        // Widest frame setting, a short frame.
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 4096);
        send_frame(6);

        // Width zero acts as one: every pixel starts a new row.
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 0);
        send_frame(8);

        // Width beyond the maximum, a short frame.
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 8191);
        send_frame(6);

        // Drain and give the verdict.
        wait_drained();
        if (fail_count == 0 && records_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
